### rtl/core/bfrx_pkg.sv
package bfrx_pkg;

  // Frame layout
  localparam int unsigned MaxData  = 32;   // largest payload kept, 1..63
  localparam int unsigned CntW     = 6;    // payload_count field width
  localparam int unsigned IdxW     = (MaxData > 1) ? $clog2(MaxData) : 1;
  localparam int unsigned NumBanks = 2;    // one payload bank per queued frame
  localparam int unsigned BankW    = 1;
  localparam int unsigned AddrW    = BankW + IdxW;
  localparam int unsigned MemDepth = NumBanks * (2 ** IdxW);
  localparam int unsigned QDepth   = NumBanks;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;

  localparam logic [7:0] MinLen   = 8'd3;
  localparam logic [7:0] MaxData8 = 8'(MaxData);

  // Byte positions inside a frame
  localparam logic [8:0] PosSrc  = 9'd0;
  localparam logic [8:0] PosLen  = 9'd1;
  localparam logic [8:0] PosDst  = 9'd2;
  localparam logic [8:0] PosCmd  = 9'd3;
  localparam logic [8:0] PosData = 9'd4;

  localparam logic KindHead = 1'b0;
  localparam logic KindData = 1'b1;

  typedef struct packed {
    logic [7:0]      src;
    logic [7:0]      dst;
    logic [7:0]      cmd;
    logic [CntW-1:0] cnt;
    logic [7:0]      chk;
    logic [BankW-1:0] bank;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      src;
    logic [7:0]      dst;
    logic [7:0]      cmd;
    logic [CntW-1:0] cnt;
    logic [7:0]      chk;
    logic [7:0]      data;
    logic            last;
  } out_t;

endpackage

### rtl/core/bfrx_deframer.sv
module bfrx_deframer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output bfrx_pkg::desc_t desc_o,
  output bfrx_pkg::wr_t   wr_o
);
  import bfrx_pkg::*;

  logic [8:0]       pos_q, pos_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       src_q, src_d;
  logic [7:0]       dst_q, dst_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       xor_q, xor_d;
  logic [BankW-1:0] bank_q, bank_d;

  logic       accept;
  logic [8:0] pos_end;
  logic [7:0] dlen;
  logic [8:0] idx9;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign pos_end    = {1'b0, len_q} + 9'd1;
  assign dlen       = len_q - MinLen;
  assign idx9       = pos_q - PosData;

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    src_d  = src_q;
    dst_d  = dst_q;
    cmd_d  = cmd_q;
    xor_d  = xor_q;
    bank_d = bank_q;
    push_o = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.addr = {bank_q, idx9[IdxW-1:0]};
    wr_o.data = rx_byte_i;
    desc_o.src  = src_q;
    desc_o.dst  = dst_q;
    desc_o.cmd  = cmd_q;
    desc_o.cnt  = dlen[CntW-1:0];
    desc_o.chk  = rx_byte_i;
    desc_o.bank = bank_q;
    if (accept) begin
      if (pos_q == PosSrc) begin
        src_d = rx_byte_i;
        xor_d = rx_byte_i;
        pos_d = PosLen;
      end else if (pos_q == PosLen) begin
        if (rx_byte_i < MinLen) begin
          // too short: slide by one byte
          src_d = rx_byte_i;
          xor_d = rx_byte_i;
        end else begin
          len_d = rx_byte_i;
          xor_d = xor_q ^ rx_byte_i;
          pos_d = PosDst;
        end
      end else if (pos_q == pos_end) begin
        if ((xor_q == rx_byte_i) && (dlen <= MaxData8)) begin
          push_o = 1'b1;
          bank_d = bank_q + 1'b1;
        end
        pos_d = PosSrc;
        xor_d = 8'd0;
      end else begin
        if (pos_q == PosDst) begin
          dst_d = rx_byte_i;
        end else if (pos_q == PosCmd) begin
          cmd_d = rx_byte_i;
        end else if (idx9 < 9'(MaxData)) begin
          wr_o.en = 1'b1;
        end
        xor_d = xor_q ^ rx_byte_i;
        pos_d = pos_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosSrc;
      len_q  <= 8'd0;
      xor_q  <= 8'd0;
      bank_q <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      xor_q  <= xor_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
    cmd_q <= cmd_d;
  end

  // once past the length byte, position never runs beyond the check byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q >= PosDst) |-> ((len_q >= MinLen) && (pos_q <= pos_end)))
    else $error("frame position beyond check byte");

endmodule

### rtl/core/bfrx_desc_fifo.sv
module bfrx_desc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bfrx_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bfrx_pkg::desc_t desc_o
);
  import bfrx_pkg::*;

  desc_t            entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign desc_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= desc_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("descriptor push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("descriptor pop from empty queue");

endmodule

### rtl/core/bfrx_emitter.sv
module bfrx_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfrx_pkg::wr_t   wr_i,
  input  logic            desc_valid_i,
  input  bfrx_pkg::desc_t desc_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bfrx_pkg::out_t  out_o
);
  import bfrx_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_READ = 4'b0100,
    S_DATA = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;
  logic [7:0]      mem_q [MemDepth];
  logic [7:0]      rd_data_q;
  logic            rd_en;
  logic            out_free;
  logic            data_last;
  logic [CntW-1:0] idx_inc;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign idx_inc   = idx_q + 1'b1;
  assign data_last = (idx_inc == desc_i.cnt);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (desc_valid_i) state_d = S_HEAD;
      end
      S_HEAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = KindHead;
          out_d.src   = desc_i.src;
          out_d.dst   = desc_i.dst;
          out_d.cmd   = desc_i.cmd;
          out_d.cnt   = desc_i.cnt;
          out_d.chk   = desc_i.chk;
          out_d.data  = 8'd0;
          out_d.last  = (desc_i.cnt == '0);
          if (desc_i.cnt == '0) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = KindData;
          out_d.src   = 8'd0;
          out_d.dst   = 8'd0;
          out_d.cmd   = 8'd0;
          out_d.cnt   = '0;
          out_d.chk   = 8'd0;
          out_d.data  = rd_data_q;
          out_d.last  = data_last;
          if (data_last) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // payload store: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    if (rd_en)   rd_data_q <= mem_q[{desc_i.bank, idx_q[IdxW-1:0]}];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> desc_valid_i)
    else $error("emitter busy without a queued frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_READ) || (state_q == S_DATA)) |-> (idx_q < desc_i.cnt))
    else $error("payload read past frame length");

endmodule

### rtl/core/bus_frame_receiver_xor_check.sv
// Order: the header transaction is registered from the queued descriptor after the check byte
//   is accepted; each following data transaction takes a store read, then an output load.
// Throughput: one rx byte per cycle while fewer than two good frames wait for output;
//   the input stalls when both payload banks hold frames not yet fully sent.
// Reset: asynchronous, active low; clears the frame position, queue and output valid.
//   Payload store contents are not cleared and need no clearing pass.
module bus_frame_receiver_xor_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  // receive side
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // result side
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       item_kind_o,
  output logic [7:0] source_addr_o,
  output logic [7:0] dest_addr_o,
  output logic [7:0] command_o,
  output logic [5:0] payload_count_o,
  output logic [7:0] check_byte_o,
  output logic [7:0] payload_byte_o,
  output logic       last_of_frame_o
);
  import bfrx_pkg::*;

  // front -> queue
  logic  push;
  desc_t push_desc;
  wr_t   wr;
  // queue -> back
  logic  q_full;
  logic  q_valid;
  logic  pop;
  desc_t head_desc;
  out_t  res;

  // Front: tracks byte position, running XOR and header bytes, writes data
  // bytes into the current payload bank and queues a descriptor for each
  // frame that passes the check and whose payload fits.
  bfrx_deframer u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .desc_o     (push_desc),
    .wr_o       (wr)
  );

  // Two-entry descriptor queue; one entry per payload bank, so a bank is
  // freed only when its frame's last transaction has been loaded.
  bfrx_desc_fifo u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (head_desc)
  );

  // Back: sends the header, then reads data bytes out of the store one at
  // a time into the output register.
  bfrx_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .desc_valid_i (q_valid),
    .desc_i       (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (res)
  );

  assign item_kind_o     = res.kind;
  assign source_addr_o   = res.src;
  assign dest_addr_o     = res.dst;
  assign command_o       = res.cmd;
  assign payload_count_o = res.cnt;
  assign check_byte_o    = res.chk;
  assign payload_byte_o  = res.data;
  assign last_of_frame_o = res.last;

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfrx_pkg::*;

  // Run limits
  localparam int unsigned CycleLimit  = 400000;  // watchdog, far above the slowest legal run
  localparam int unsigned DrainCycles = 20;      // wait for stray transactions after the queue empties
  localparam int unsigned ShowLimit   = 10;      // mismatches printed in full

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       item_kind_o;
  logic [7:0] source_addr_o;
  logic [7:0] dest_addr_o;
  logic [7:0] command_o;
  logic [5:0] payload_count_o;
  logic [7:0] check_byte_o;
  logic [7:0] payload_byte_o;
  logic       last_of_frame_o;

  bus_frame_receiver_xor_check i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .source_addr_o  (source_addr_o),
    .dest_addr_o    (dest_addr_o),
    .command_o      (command_o),
    .payload_count_o(payload_count_o),
    .check_byte_o   (check_byte_o),
    .payload_byte_o (payload_byte_o),
    .last_of_frame_o(last_of_frame_o)
  );

  // Deframer shadow state: mirrors what the block holds for the frame in flight
  logic [8:0] frame_pos = PosSrc;
  logic [7:0] cur_src   = '0;
  logic [7:0] cur_len   = '0;
  logic [7:0] cur_dst   = '0;
  logic [7:0] cur_cmd   = '0;
  logic [7:0] cur_xor   = '0;
  logic [7:0] payload_mem [MaxData];

  // Results of good frames, oldest first, waiting for the result port
  out_t deframed_q [$];

  int unsigned sent_count  = 0;  // rx bytes accepted so far
  int unsigned bad_count   = 0;  // mismatches plus unexpected results
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;  // long receiver hold-off, counted down per cycle
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Feed one accepted rx byte through the shadow deframer. A good frame
  // queues its header and then one transaction per data byte.
  task automatic deframe_byte(input logic [7:0] b);
    out_t        r;
    int unsigned dlen;
    if (frame_pos == PosSrc) begin
      cur_src   = b;
      cur_xor   = b;
      frame_pos = PosLen;
    end else if (frame_pos == PosLen) begin
      if (b < MinLen) begin
        // too short to be a length: slide, this byte is the new source
        cur_src = b;
        cur_xor = b;
      end else begin
        cur_len   = b;
        cur_xor   = cur_xor ^ b;
        frame_pos = PosDst;
      end
    end else if (frame_pos == {1'b0, cur_len} + 9'd1) begin
      // check byte: emit only on XOR match and a payload that fits
      dlen = int'(cur_len) - int'(MinLen);
      if (cur_xor == b && dlen <= MaxData) begin
        r      = '0;
        r.kind = KindHead;
        r.src  = cur_src;
        r.dst  = cur_dst;
        r.cmd  = cur_cmd;
        r.cnt  = CntW'(dlen);
        r.chk  = b;
        r.last = (dlen == 0);
        deframed_q.push_back(r);
        for (int i = 0; i < dlen; i++) begin
          r      = '0;
          r.kind = KindData;
          r.data = payload_mem[i];
          r.last = (i + 1 == dlen);
          deframed_q.push_back(r);
        end
      end
      frame_pos = PosSrc;
      cur_xor   = '0;
    end else begin
      if (frame_pos == PosDst) begin
        cur_dst = b;
      end else if (frame_pos == PosCmd) begin
        cur_cmd = b;
      end else if (frame_pos - PosData < MaxData) begin
        payload_mem[frame_pos - PosData] = b;
      end
      cur_xor   = cur_xor ^ b;
      frame_pos = frame_pos + 9'd1;
    end
  endtask

  // Offer one rx byte. Entered and left at a falling edge; valid stays high
  // into the next call when that one draws no gap.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Whole frame: src, len, dst, cmd, len-3 random data bytes, check byte.
  task automatic send_frame(input logic [7:0] src, input logic [7:0] len,
                            input logic [7:0] dst, input logic [7:0] cmd,
                            input bit corrupt);
    logic [7:0] sum;
    logic [7:0] d;
    sum = src ^ len ^ dst ^ cmd;
    send_byte(src);
    send_byte(len);
    send_byte(dst);
    send_byte(cmd);
    for (int i = 3; i < len; i++) begin
      d   = 8'($urandom_range(0, 255));
      sum = sum ^ d;
      send_byte(d);
    end
    send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  // Header-only frames, field extremes, a slide over short lengths and a bad check.
  task automatic test_directed_frames();
    send_frame(8'h00, 8'd3, 8'hFF, 8'h00, 1'b0);
    send_frame(8'hFF, 8'd4, 8'h00, 8'hFF, 1'b0);
    // junk source, then lengths 0 and 1 slide; frame source 2 slides once more
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h01);
    send_frame(8'h02, 8'd3, 8'hA5, 8'h3C, 1'b0);
    send_frame(8'h12, 8'd5, 8'h34, 8'h56, 1'b1);
  endtask

  // Largest payload kept, then one byte too many.
  task automatic test_oversize_frames();
    send_frame(8'($urandom_range(0, 255)), 8'd35, 8'hC3, 8'h7E, 1'b0);
    send_frame(8'($urandom_range(0, 255)), 8'd36, 8'h81, 8'h18, 1'b0);
  endtask

  // Receiver holds off while frames keep coming: both banks fill, input stalls.
  task automatic test_input_backpressure();
    hold_left  = 300;
    tx_idle_on = 1'b0;
    repeat (3) begin
      send_frame(8'($urandom_range(0, 255)), 8'd5, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b0);
    end
    tx_idle_on = 1'b1;
  endtask

  // Mostly good frames with random content; some bad checks, slides and noise.
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned pick;
    logic [7:0]  len;
    first = sent_count;
    while (sent_count - first < 20) begin
      if ($urandom_range(0, 3) == 0) tx_idle_on = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) rx_idle_on = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 11);
      len  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(30, 38))
                                          : 8'($urandom_range(3, 10));
      if (pick < 8) begin
        send_frame(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b0);
      end else if (pick == 8) begin
        send_frame(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b1);
      end else if (pick == 9) begin
        send_byte(8'($urandom_range(0, 255)));
        send_frame(8'($urandom_range(0, 2)), len, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // raw noise with small values, then run out whatever frame it opened
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 15)));
        while (frame_pos != PosSrc) send_byte(8'($urandom_range(0, 15)));
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Result side stall: a random wait before each transaction, or the long hold.
  initial begin : result_stall
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      while (hold_left > 0) begin
        out_stall_i = 1'b1;
        @(negedge clk_i);
      end
      gap = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : hold_timer
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) hold_left--;
    end
  end

  // Compare every accepted result transaction with the oldest queued one.
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deframed_q.size() == 0) begin
        bad_count++;
        if (bad_count <= ShowLimit) begin
          $display("%0t: unexpected result kind=%0b src=%h data=%h last=%0b", $realtime,
                   item_kind_o, source_addr_o, payload_byte_o, last_of_frame_o);
        end
      end else begin
        want = deframed_q.pop_front();
        if (item_kind_o !== want.kind || source_addr_o !== want.src ||
            dest_addr_o !== want.dst || command_o !== want.cmd ||
            payload_count_o !== want.cnt || check_byte_o !== want.chk ||
            payload_byte_o !== want.data || last_of_frame_o !== want.last) begin
          bad_count++;
          if (bad_count <= ShowLimit) begin
            $display("%0t: mismatch kind %0b/%0b src %h/%h dst %h/%h cmd %h/%h", $realtime,
                     want.kind, item_kind_o, want.src, source_addr_o,
                     want.dst, dest_addr_o, want.cmd, command_o);
            $display("  cnt %0d/%0d chk %h/%h data %h/%h last %0b/%0b (expected/actual)",
                     want.cnt, payload_count_o, want.chk, check_byte_o,
                     want.data, payload_byte_o, want.last, last_of_frame_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_stall_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_frames();
    test_oversize_frames();
    test_input_backpressure();
    test_random_traffic();

    in_valid_i = 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    // let any stray transaction show up before judging
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bfrx_pkg.sv
rtl/core/bfrx_deframer.sv
rtl/core/bfrx_desc_fifo.sv
rtl/core/bfrx_emitter.sv
rtl/core/bus_frame_receiver_xor_check.sv
bench/tb.sv
